@@ rtl/cea_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helpers of the class evidence accumulator
package cea_pkg;

	localparam int unsigned MAX_CLASSES_DEF = 4;
	localparam int unsigned NUM_LANES       = 4;
	localparam int unsigned CLASS_W         = 2;
	localparam int unsigned Q15_W           = 16;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [Q15_W-1:0] ONE_Q15  = 16'd32768;
	localparam logic [Q15_W-1:0] HALF_Q15 = 16'd16384;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_STEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLASSES    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLDS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_VALS  = 3'd5;

	// step modes
	localparam logic [1:0] MODE_HARD = 2'd0;
	localparam logic [1:0] MODE_SOFT = 2'd1;

	localparam logic [1:0]  STEP_MODE_RST = MODE_SOFT;
	localparam logic [15:0] GAIN_RST      = 16'd640;
	localparam logic [15:0] UNIT_STEP_RST = 16'd512;
	localparam logic [2:0]  CLASSES_RST   = 3'd2;
	localparam logic [63:0] THRESH_RST    = 64'h4000_4000_4000_4000;
	localparam logic [63:0] INIT_VALS_RST = 64'h4000_4000_4000_4000;

	typedef struct packed {
		logic [1:0]  step_mode;
		logic [15:0] gain;
		logic [15:0] unit_step;
		logic [2:0]  classes_in_use;
		logic [63:0] thresholds;
		logic [63:0] init_vals;
	} cfg_t;

	// classified request handed from front to back
	typedef struct packed {
		logic               restart;
		logic [CLASS_W-1:0] winner;
		logic [Q15_W-1:0]   pmax;
		logic               pass;
	} cls_t;

	function automatic logic [2:0] lanes_used(input logic [2:0] cin, input int unsigned max_cls);
		logic [2:0] n;
		n = cin;
		if (n == 3'd0)
			n = 3'd1;
		if (32'(n) > max_cls)
			n = 3'(max_cls);
		return n;
	endfunction

	function automatic logic [Q15_W-1:0] sat_one(input logic [Q15_W-1:0] v);
		return (v > ONE_Q15) ? ONE_Q15 : v;
	endfunction

endpackage

@@ rtl/cea_if.sv @@
`timescale 1ns / 1ps
// request, result and configuration channels of the class evidence accumulator
interface cea_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] prob_0;
	logic [15:0] prob_1;
	logic [15:0] prob_2;
	logic [15:0] prob_3;
	modport source(output valid, operation, prob_0, prob_1, prob_2, prob_3, input ready);
	modport sink(input valid, operation, prob_0, prob_1, prob_2, prob_3, output ready);
endinterface

interface cea_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] acc_0;
	logic [15:0] acc_1;
	logic [15:0] acc_2;
	logic [15:0] acc_3;
	logic [1:0]  winner;
	logic        accepted;
	modport source(output valid, acc_0, acc_1, acc_2, acc_3, winner, accepted, input ready);
	modport sink(input valid, acc_0, acc_1, acc_2, acc_3, winner, accepted, output ready);
endinterface

interface cea_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/cea_front.sv @@
`timescale 1ns / 1ps
// front end: takes requests, picks the winner and checks its threshold
module cea_front import cea_pkg::*; #(
	parameter int unsigned MAX_CLASSES = MAX_CLASSES_DEF
) (
	cea_in_if.sink     req,
	input  cfg_t       cfg_q,
	input  logic       q_full,
	output logic       q_push,
	output cls_t       q_data
);

	logic [Q15_W-1:0]   prob [NUM_LANES];
	logic [2:0]         n_lanes;
	logic [Q15_W-1:0]   pmax;
	logic [CLASS_W-1:0] win;
	logic [Q15_W-1:0]   thr;

	assign prob[0] = req.prob_0;
	assign prob[1] = req.prob_1;
	assign prob[2] = req.prob_2;
	assign prob[3] = req.prob_3;

	assign n_lanes   = lanes_used(cfg_q.classes_in_use, MAX_CLASSES);
	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;

	// first lane with the largest probability
	always_comb begin
		pmax = prob[0];
		win  = '0;
		for (int i = 1; i < NUM_LANES; i++) begin
			if (i < 32'(n_lanes) && prob[i] > pmax) begin
				pmax = prob[i];
				win  = CLASS_W'(i);
			end
		end
	end

	assign thr = cfg_q.thresholds[win*Q15_W +: Q15_W];

	always_comb begin
		q_data.restart = req.operation;
		q_data.pmax    = pmax;
		if (req.operation) begin
			q_data.winner = '0;
			q_data.pass   = 1'b0;
		end else begin
			q_data.winner = win;
			q_data.pass   = (pmax > thr) && (cfg_q.step_mode inside {MODE_HARD, MODE_SOFT});
		end
	end

endmodule

@@ rtl/cea_fifo.sv @@
`timescale 1ns / 1ps
// short register queue between front and back
module cea_fifo import cea_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_data,
	output logic full,
	input  logic pop,
	output cls_t pop_data,
	output logic empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cls_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ rtl/cea_back.sv @@
`timescale 1ns / 1ps
// back end: step size, evidence update and result register
module cea_back import cea_pkg::*; #(
	parameter int unsigned MAX_CLASSES = MAX_CLASSES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg_q,
	input  logic       q_empty,
	input  cls_t       q_data,
	output logic       q_pop,
	cea_out_if.source  rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL1 = 2'd1;
	localparam logic [1:0] ST_MUL2 = 2'd2;
	localparam logic [1:0] ST_UPD  = 2'd3;

	logic [1:0]       state_q;
	cls_t             rec_q;
	logic [Q15_W-1:0] dev_q;
	logic [31:0]      prod_q;
	logic [Q15_W-1:0] step_q;

	logic [Q15_W-1:0] ev_q   [MAX_CLASSES];
	logic [Q15_W-1:0] ev_new [MAX_CLASSES];
	logic [Q15_W-1:0] acc_lane [NUM_LANES];

	logic [Q15_W-1:0] acc_q [NUM_LANES];
	logic [CLASS_W-1:0] winner_q;
	logic             accepted_q;
	logic             rsp_valid_q;

	logic [2:0]       n_lanes;
	logic [Q15_W-1:0] dev;
	logic [24:0]      vel_full;
	logic [Q15_W-1:0] vel;
	logic [31:0]      mul1;
	logic [31:0]      mul2;
	logic             load_out;

	assign n_lanes = lanes_used(cfg_q.classes_in_use, MAX_CLASSES);
	assign q_pop   = (state_q == ST_IDLE) && !q_empty;
	assign dev     = (q_data.pmax >= HALF_Q15) ? q_data.pmax - HALF_Q15 : HALF_Q15 - q_data.pmax;

	assign mul1     = 32'(dev_q) * 32'(cfg_q.gain);
	// d * 2 * gain >> 8, saturated to one
	assign vel_full = prod_q[31:7];
	assign vel      = (vel_full > 25'(ONE_Q15)) ? ONE_Q15 : vel_full[Q15_W-1:0];
	assign mul2     = 32'(cfg_q.unit_step) * 32'(vel);

	assign load_out = (state_q == ST_UPD) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		for (int i = 0; i < MAX_CLASSES; i++) begin
			logic [17:0] sum;
			sum = 18'(ev_q[i]) + 18'(step_q);
			ev_new[i] = ev_q[i];
			if (rec_q.restart) begin
				ev_new[i] = sat_one(cfg_q.init_vals[i*Q15_W +: Q15_W]);
			end else if (rec_q.pass && i < 32'(n_lanes)) begin
				if (i == 32'(rec_q.winner))
					ev_new[i] = (sum > 18'(ONE_Q15)) ? ONE_Q15 : sum[Q15_W-1:0];
				else
					ev_new[i] = (step_q > ev_q[i]) ? '0 : ev_q[i] - step_q;
			end
		end
	end

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		if (g < MAX_CLASSES) begin : g_used
			assign acc_lane[g] = (g < 32'(n_lanes)) ? ev_new[g] : '0;
		end else begin : g_absent
			assign acc_lane[g] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < MAX_CLASSES; i++)
				ev_q[i] <= sat_one(INIT_VALS_RST[i*Q15_W +: Q15_W]);
		end else begin
			if (rsp_valid_q && rsp.ready && !load_out)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (q_data.pass && cfg_q.step_mode == MODE_SOFT)
							state_q <= ST_MUL1;
						else
							state_q <= ST_UPD;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_UPD;
				ST_UPD: begin
					if (load_out) begin
						rsp_valid_q <= 1'b1;
						ev_q        <= ev_new;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rec_q  <= q_data;
			dev_q  <= dev;
			step_q <= cfg_q.unit_step;
		end
		if (state_q == ST_MUL1)
			prod_q <= mul1;
		if (state_q == ST_MUL2)
			step_q <= mul2[30:15];
		if (load_out) begin
			acc_q      <= acc_lane;
			winner_q   <= rec_q.winner;
			accepted_q <= rec_q.pass && !rec_q.restart;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.acc_0    = acc_q[0];
	assign rsp.acc_1    = acc_q[1];
	assign rsp.acc_2    = acc_q[2];
	assign rsp.acc_3    = acc_q[3];
	assign rsp.winner   = winner_q;
	assign rsp.accepted = accepted_q;

endmodule

@@ rtl/class_evidence_accumulator_unit.sv @@
`timescale 1ns / 1ps
// Class evidence accumulator: per-class probability requests in, per-class
// evidence (Q1.15, clipped to [0, 1]) out, one result per request. The front
// end picks the first class with the largest probability and checks it against
// that class's rejection threshold in the cycle the request is taken; a queue of
// QUEUE_DEPTH entries separates it from the back end, which works on one request
// at a time. A soft-mode step runs through two registered multiplies (distance
// times gain, then unit step times velocity) in states MUL1 and MUL2, while hard
// mode, invalid mode, rejected samples and restarts go straight from idle to the
// update, which also waits on rsp.ready while an earlier result is not yet taken.
// Configuration writes are always taken (cfg.ready is tied high) and must only
// be issued while no request is in flight. Unused lanes report zero evidence.
module class_evidence_accumulator_unit import cea_pkg::*; #(
	parameter int unsigned MAX_CLASSES = MAX_CLASSES_DEF,
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cea_in_if.sink     req,
	cea_out_if.source  rsp,
	cea_cfg_if.sink    cfg
);

	cfg_t cfg_q;
	cls_t push_data;
	cls_t pop_data;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;

	// configuration registers, written one index per request
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_mode      <= STEP_MODE_RST;
			cfg_q.gain           <= GAIN_RST;
			cfg_q.unit_step      <= UNIT_STEP_RST;
			cfg_q.classes_in_use <= CLASSES_RST;
			cfg_q.thresholds     <= THRESH_RST;
			cfg_q.init_vals      <= INIT_VALS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_STEP_MODE:  cfg_q.step_mode      <= cfg.data[1:0];
				REG_GAIN:       cfg_q.gain           <= cfg.data[15:0];
				REG_UNIT_STEP:  cfg_q.unit_step      <= cfg.data[15:0];
				REG_CLASSES:    cfg_q.classes_in_use <= cfg.data[2:0];
				REG_THRESHOLDS: cfg_q.thresholds     <= cfg.data;
				REG_INIT_VALS:  cfg_q.init_vals      <= cfg.data;
				default: ;
			endcase
		end
	end

	// front end: winner search and threshold check
	cea_front #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_front (
		.req    (req),
		.cfg_q  (cfg_q),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (push_data)
	);

	// decoupling queue between classification and update
	cea_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	// back end: step computation, evidence update, result register
	cea_back #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_q   (cfg_q),
		.q_empty (q_empty),
		.q_data  (pop_data),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

	// an accepted step needs a valid step mode
	a_accept_mode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.accepted |-> (cfg_q.step_mode == MODE_HARD || cfg_q.step_mode == MODE_SOFT))
		else $error("accepted result under invalid step mode");

	// evidence stays clipped to one
	a_acc_clip: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.acc_0 <= ONE_Q15 && rsp.acc_1 <= ONE_Q15 &&
			rsp.acc_2 <= ONE_Q15 && rsp.acc_3 <= ONE_Q15))
		else $error("evidence above one");

	// winner is always a lane in use
	a_winner_lane: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> 3'(rsp.winner) < lanes_used(cfg_q.classes_in_use, MAX_CLASSES))
		else $error("winner outside lanes in use");

endmodule

@@ verif/cea_evidence_checker.sv @@
`timescale 1ns / 1ps
// predictor and result checker of the class evidence accumulator testbench
module cea_evidence_checker import cea_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cea_in_if           req,
	cea_out_if          rsp,
	cea_cfg_if          cfg,
	output int unsigned errors,
	output int unsigned outstanding
);

	typedef struct packed {
		logic [NUM_LANES-1:0][Q15_W-1:0] acc;
		logic [CLASS_W-1:0]              winner;
		logic                            accepted;
	} evidence_t;

	cfg_t             regs;
	logic [Q15_W-1:0] evidence [NUM_LANES];
	evidence_t        expected_evidence [$];

	// start value of one lane, saturated to 1.0
	function automatic logic [Q15_W-1:0] start_level(input logic [63:0] vals, input int lane);
		logic [Q15_W-1:0] v;
		v = vals[lane*Q15_W +: Q15_W];
		return (v > ONE_Q15) ? ONE_Q15 : v;
	endfunction

	// advances the evidence copy by one request and returns the result it gives
	function automatic evidence_t predict_evidence(input logic restart,
			input logic [NUM_LANES-1:0][Q15_W-1:0] prob);
		evidence_t        res;
		int unsigned      lanes;
		logic [Q15_W-1:0] pmax;
		logic [Q15_W-1:0] dev;
		logic [63:0]      velocity;
		int               step;
		int               level;
		res = '0;
		lanes = regs.classes_in_use;
		if (lanes == 0)
			lanes = 1;
		if (lanes > MAX_CLASSES_DEF)
			lanes = MAX_CLASSES_DEF;
		if (restart) begin
			for (int i = 0; i < NUM_LANES; i++)
				evidence[i] = start_level(regs.init_vals, i);
		end else begin
			pmax = prob[0];
			for (int i = 1; i < lanes; i++) begin
				if (prob[i] > pmax) begin
					pmax = prob[i];
					res.winner = CLASS_W'(i);
				end
			end
			if (pmax > regs.thresholds[res.winner*Q15_W +: Q15_W] &&
					(regs.step_mode == MODE_HARD || regs.step_mode == MODE_SOFT)) begin
				if (regs.step_mode == MODE_HARD) begin
					step = int'(regs.unit_step);
				end else begin
					dev = (pmax >= HALF_Q15) ? pmax - HALF_Q15 : HALF_Q15 - pmax;
					velocity = (64'(dev) * 64'd2 * 64'(regs.gain)) >> 8;
					if (velocity > 64'(ONE_Q15))
						velocity = 64'(ONE_Q15);
					step = int'((64'(regs.unit_step) * velocity) >> 15);
				end
				for (int i = 0; i < lanes; i++) begin
					level = int'(evidence[i]);
					level = (i == int'(res.winner)) ? level + step : level - step;
					if (level < 0)
						level = 0;
					if (level > int'(ONE_Q15))
						level = int'(ONE_Q15);
					evidence[i] = Q15_W'(level);
				end
				res.accepted = 1'b1;
			end
		end
		for (int i = 0; i < NUM_LANES; i++)
			res.acc[i] = (i < lanes) ? evidence[i] : '0;
		return res;
	endfunction

	function automatic void check_field(input string label, input logic [Q15_W-1:0] want,
			input logic [Q15_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, label, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		evidence_t got;
		evidence_t want;
		if (!arst_n) begin
			regs.step_mode      = STEP_MODE_RST;
			regs.gain           = GAIN_RST;
			regs.unit_step      = UNIT_STEP_RST;
			regs.classes_in_use = CLASSES_RST;
			regs.thresholds     = THRESH_RST;
			regs.init_vals      = INIT_VALS_RST;
			for (int i = 0; i < NUM_LANES; i++)
				evidence[i] = start_level(INIT_VALS_RST, i);
			expected_evidence.delete();
			errors      = 0;
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_STEP_MODE:  regs.step_mode      = cfg.data[1:0];
					REG_GAIN:       regs.gain           = cfg.data[15:0];
					REG_UNIT_STEP:  regs.unit_step      = cfg.data[15:0];
					REG_CLASSES:    regs.classes_in_use = cfg.data[2:0];
					REG_THRESHOLDS: regs.thresholds     = cfg.data;
					REG_INIT_VALS:  regs.init_vals      = cfg.data;
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				expected_evidence.push_back(predict_evidence(req.operation,
					{req.prob_3, req.prob_2, req.prob_1, req.prob_0}));
			if (rsp.valid && rsp.ready) begin
				got = {rsp.acc_3, rsp.acc_2, rsp.acc_1, rsp.acc_0, rsp.winner, rsp.accepted};
				if (expected_evidence.size() == 0) begin
					$display("%0t: unexpected result, expected none got %h", $time, got);
					errors++;
				end else begin
					want = expected_evidence.pop_front();
					check_field("acc_0", want.acc[0], got.acc[0]);
					check_field("acc_1", want.acc[1], got.acc[1]);
					check_field("acc_2", want.acc[2], got.acc[2]);
					check_field("acc_3", want.acc[3], got.acc[3]);
					check_field("winner", Q15_W'(want.winner), Q15_W'(got.winner));
					check_field("accepted", Q15_W'(want.accepted), Q15_W'(got.accepted));
				end
			end
			outstanding = expected_evidence.size();
		end
	end

endmodule

@@ verif/tb_class_evidence_accumulator_unit.sv @@
`timescale 1ns / 1ps
// stimulus and verdict for the class evidence accumulator unit
module tb_class_evidence_accumulator_unit;
	import cea_pkg::*;

	localparam logic        OP_SAMPLE    = 1'b0;
	localparam logic        OP_RESTART   = 1'b1;
	// step modes with no update
	localparam logic [1:0]  MODE_VOID2   = 2'd2;
	localparam logic [1:0]  MODE_VOID3   = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 1830;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	// a request passes at most the MUL1, MUL2 and UPD states of the back end, plus the queue
	localparam int unsigned TAIL_CYCLES  = 16;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned check_errors;
	int unsigned outstanding;
	int unsigned burst_left;

	cea_in_if  req_if();
	cea_out_if rsp_if();
	cea_cfg_if cfg_if();

	class_evidence_accumulator_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	cea_evidence_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_if),
		.rsp         (rsp_if),
		.cfg         (cfg_if),
		.errors      (check_errors),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_class_evidence_accumulator_unit: errors");
		$finish;
	end

	// result backpressure, switching style whenever a random run length is used up
	initial begin
		int unsigned stall_style;
		int unsigned style_left;
		int unsigned tick;
		rsp_if.ready = 1'b0;
		stall_style = 0;
		style_left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (style_left == 0) begin
				stall_style = $urandom_range(0, 3);
				style_left = $urandom_range(50, 300);
			end
			style_left--;
			tick++;
			case (stall_style)
				0: rsp_if.ready = 1'b1;                           // always ready
				1: rsp_if.ready = ($urandom_range(0, 1) == 0);    // coin flip
				2: rsp_if.ready = ((tick % 7) >= 3);              // periodic stall
				default: rsp_if.ready = ($urandom_range(0, 9) == 0); // heavy stall
			endcase
		end
	end

	// one request; entered at a falling edge, left at a falling edge with valid
	// still high when the burst goes on, or after a random gap otherwise
	task automatic issue(input logic op, input logic [15:0] p0, input logic [15:0] p1,
			input logic [15:0] p2, input logic [15:0] p3);
		req_if.valid     = 1'b1;
		req_if.operation = op;
		req_if.prob_0    = p0;
		req_if.prob_1    = p1;
		req_if.prob_2    = p2;
		req_if.prob_3    = p3;
		do
			@(posedge clk);
		while (!req_if.ready);
		@(negedge clk);
		if (burst_left == 0) begin
			req_if.valid = 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 4))
				@(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end else begin
			burst_left--;
		end
	endtask

	// register write; only while nothing is in flight
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = value;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// hold off requests until every result has come back
	task automatic drain();
		req_if.valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// four packed lanes of thresholds or start values, extremes mixed in
	function automatic logic [63:0] pick_lanes(input bit start_vals);
		logic [63:0] vals;
		for (int i = 0; i < NUM_LANES; i++) begin
			case ($urandom_range(0, 9))
				0: vals[i*16 +: 16] = 16'd0;
				1: vals[i*16 +: 16] = ONE_Q15;
				2: vals[i*16 +: 16] = 16'hFFFF;
				3: vals[i*16 +: 16] = 16'($urandom_range(0, 65535));
				default: vals[i*16 +: 16] = start_vals ? 16'($urandom_range(0, 32768))
					: 16'($urandom_range(0, 24576));
			endcase
		end
		return vals;
	endfunction

	initial begin
		logic        op;
		logic [15:0] prob [4];
		logic [15:0] top_prob;
		int unsigned sent;
		int unsigned phase_len;
		int unsigned favored;
		int unsigned style;
		int unsigned k1;
		int unsigned k2;
		bit          first_phase;

		req_if.valid     = 1'b0;
		req_if.operation = OP_SAMPLE;
		req_if.prob_0    = '0;
		req_if.prob_1    = '0;
		req_if.prob_2    = '0;
		req_if.prob_3    = '0;
		cfg_if.valid     = 1'b0;
		cfg_if.index     = REG_STEP_MODE;
		cfg_if.data      = '0;
		burst_left       = 0;
		arst_n           = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset settings: soft mode, two classes, thresholds at one half
		issue(OP_RESTART, 16'd0, 16'd0, 16'd0, 16'd0);
		issue(OP_SAMPLE, 16'd32768, 16'd0, 16'd0, 16'd0);       // full velocity
		issue(OP_SAMPLE, 16'd0, 16'd32768, 16'hFFFF, 16'hFFFF); // unused lanes ignored
		issue(OP_SAMPLE, 16'd20000, 16'd20000, 16'd0, 16'd0);   // tie goes to class 0
		issue(OP_SAMPLE, 16'd16384, 16'd100, 16'd0, 16'd0);     // equal to threshold
		issue(OP_SAMPLE, 16'd16385, 16'd0, 16'd0, 16'd0);       // step truncates to zero
		issue(OP_SAMPLE, 16'd0, 16'd0, 16'd0, 16'd0);
		issue(OP_SAMPLE, 16'hFFFF, 16'd1, 16'd0, 16'd0);        // probability above one
		drain();

		// hard mode, all lanes, a step that slams to the clip limits
		write_reg(REG_CLASSES, 64'd4);
		write_reg(REG_STEP_MODE, 64'(MODE_HARD));
		write_reg(REG_UNIT_STEP, 64'd32768);
		write_reg(REG_THRESHOLDS, 64'd0);
		issue(OP_SAMPLE, 16'd1, 16'd2, 16'd3, 16'd4);
		issue(OP_SAMPLE, 16'd5, 16'd5, 16'd5, 16'd5);
		issue(OP_RESTART, 16'd0, 16'd0, 16'd0, 16'd0);
		drain();

		// step modes with no update still report the winner
		write_reg(REG_STEP_MODE, 64'(MODE_VOID2));
		issue(OP_SAMPLE, 16'd0, 16'd0, 16'd30000, 16'd0);
		drain();
		write_reg(REG_STEP_MODE, 64'(MODE_VOID3));
		issue(OP_SAMPLE, 16'd0, 16'd9000, 16'd0, 16'd30000);
		drain();

		// class count out of range, start values above one
		write_reg(REG_STEP_MODE, 64'(MODE_HARD));
		write_reg(REG_CLASSES, 64'd0);
		issue(OP_SAMPLE, 16'd0, 16'd32768, 16'd32768, 16'd32768);
		drain();
		write_reg(REG_CLASSES, 64'd7);
		write_reg(REG_INIT_VALS, 64'hFFFF_8001_8000_0000);
		issue(OP_RESTART, 16'd0, 16'd0, 16'd0, 16'd0);
		drain();

		// soft mode gain extremes and the largest possible step
		write_reg(REG_STEP_MODE, 64'(MODE_SOFT));
		write_reg(REG_GAIN, 64'd0);
		issue(OP_SAMPLE, 16'd32768, 16'd0, 16'd0, 16'd0);
		drain();
		write_reg(REG_GAIN, 64'd65535);
		write_reg(REG_UNIT_STEP, 64'd65535);
		write_reg(REG_THRESHOLDS, 64'hFFFF_FFFF_FFFF_FFFF);
		issue(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);     // not above threshold
		drain();
		write_reg(REG_THRESHOLDS, 64'h7FFF_7FFF_7FFF_7FFF);
		issue(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		issue(OP_SAMPLE, 16'd0, 16'd0, 16'd0, 16'hFFFF);
		drain();

		// random phases, each opened on an idle block, each setting redrawn or kept
		sent = 0;
		first_phase = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			drain();
			if (first_phase || $urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: write_reg(REG_STEP_MODE, 64'(MODE_HARD));
					8:          write_reg(REG_STEP_MODE, 64'(MODE_VOID2));
					9:          write_reg(REG_STEP_MODE, 64'(MODE_VOID3));
					default:    write_reg(REG_STEP_MODE, 64'(MODE_SOFT));
				endcase
			end
			if (first_phase || $urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 7))
					0: write_reg(REG_GAIN, 64'd0);
					1: write_reg(REG_GAIN, 64'd65535);
					2: write_reg(REG_GAIN, 64'(GAIN_RST));
					3: write_reg(REG_GAIN, 64'($urandom_range(0, 65535)));
					default: write_reg(REG_GAIN, 64'($urandom_range(64, 2048)));
				endcase
			end
			if (first_phase || $urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 9))
					0: write_reg(REG_UNIT_STEP, 64'd1);
					1: write_reg(REG_UNIT_STEP, 64'd32768);
					2: write_reg(REG_UNIT_STEP, 64'd0);
					3: write_reg(REG_UNIT_STEP, 64'd65535);
					4: write_reg(REG_UNIT_STEP, 64'($urandom_range(0, 65535)));
					default: write_reg(REG_UNIT_STEP, 64'($urandom_range(1, 2048)));
				endcase
			end
			if (first_phase || $urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 7))
					0: write_reg(REG_CLASSES, 64'd0);
					1: write_reg(REG_CLASSES, 64'($urandom_range(5, 7)));
					2: write_reg(REG_CLASSES, 64'd1);
					default: write_reg(REG_CLASSES, 64'($urandom_range(2, 4)));
				endcase
			end
			if (first_phase || $urandom_range(0, 1) == 0)
				write_reg(REG_THRESHOLDS, pick_lanes(1'b0));
			if (first_phase || $urandom_range(0, 1) == 0)
				write_reg(REG_INIT_VALS, pick_lanes(1'b1));
			first_phase = 1'b0;

			// mostly long phases so the evidence can run into both clip limits
			phase_len = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 15)
				: $urandom_range(40, 140);
			favored = $urandom_range(0, 3);
			repeat (phase_len) begin
				op = ($urandom_range(0, 29) == 0) ? OP_RESTART : OP_SAMPLE;
				style = $urandom_range(0, 99);
				for (int i = 0; i < 4; i++)
					prob[i] = 16'($urandom_range(0, 32768));
				if (style < 60) begin
					// one class keeps winning, the rest share what is left
					if ($urandom_range(0, 15) == 0)
						favored = $urandom_range(0, 3);
					top_prob = 16'($urandom_range(16384, 32768));
					for (int i = 0; i < 4; i++)
						prob[i] = 16'($urandom_range(0, 32768 - top_prob));
					prob[favored] = top_prob;
				end else if (style < 75) begin
					// plain uniform vector, already drawn
				end else if (style < 90) begin
					// two classes tied at the top
					k1 = $urandom_range(0, 3);
					k2 = $urandom_range(0, 3);
					top_prob = 16'($urandom_range(8192, 32768));
					for (int i = 0; i < 4; i++)
						prob[i] = 16'($urandom_range(0, top_prob));
					prob[k1] = top_prob;
					prob[k2] = top_prob;
				end else begin
					// out-of-range probabilities, every bit free
					for (int i = 0; i < 4; i++)
						prob[i] = 16'($urandom_range(0, 65535));
				end
				issue(op, prob[0], prob[1], prob[2], prob[3]);
				sent++;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (check_errors == 0)
			$display("tb_class_evidence_accumulator_unit: clean");
		else
			$display("tb_class_evidence_accumulator_unit: errors");
		$finish;
	end

endmodule
